// File: design/wfos_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wfos_pkg;

  // item codes on the command field
  typedef enum logic [0:0] {
    CMD_PUSH = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  localparam int FIFO_DEPTH_DEF = 16;
  localparam int WORD_BITS_DEF  = 32;
  localparam int BYTE_BITS      = 8;
  localparam int KEY_BITS       = 32;

endpackage

`default_nettype wire

// File: design/word_fifo_onoff_serializer.sv
// word_fifo_onoff_serializer: byte packer, keyed word queue and one-bit line sender
//
// input channel (in_valid_i / in_stall_o): a push item (command 0) adds data_byte_i
// to the word being packed, first byte in the low bits; a full word, or the byte
// marked by last_byte_i, is XORed with key_word_i and queued. a tick item
// (command 1) is one bit period: an idle sender pops a word and drives the start
// bit low, then 32 data bits LSB first, a high stop bit and one closing tick.
// output channel (out_valid_o / out_stall_i): one result per item, giving line
// level, busy, queue fill and the overflow flag for that push.
// each item's result is registered, into the result register or the skid entry.
// throughput: one item per cycle while in_stall_o is low; every item is a single
// register update of the packer, queue pointers and shift register, with no iteration.
// the result register is backed by a skid entry, so an item is still taken
// while a result waits; in_stall_o rises only when both entries are full and
// drops in the cycle after the receiver takes a result.
// reset: packer empty, queue empty, sender idle, line high, no result pending.
// queue storage is not cleared; an entry is only read after it was written.
`timescale 1ns / 1ps
`default_nettype none

module word_fifo_onoff_serializer
  import wfos_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // input channel
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               command_i,
  input  wire logic [BYTE_BITS-1:0]               data_byte_i,
  input  wire logic                               last_byte_i,
  input  wire logic [KEY_BITS-1:0]                key_word_i,
  // output channel
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    line_level_o,
  output logic                                    busy_res_o,
  output logic [$clog2(FIFO_DEPTH+1)-1:0]         fifo_count_o,
  output logic                                    overflow_o
);

  localparam int BytesPerWord = (WORD_BITS / BYTE_BITS < 1) ? 1 : WORD_BITS / BYTE_BITS;
  localparam int PosW         = (BytesPerWord > 1) ? $clog2(BytesPerWord) : 1;
  localparam int AddrW        = $clog2(FIFO_DEPTH);
  localparam int CntW         = $clog2(FIFO_DEPTH + 1);
  localparam int IdxW         = $clog2(WORD_BITS + 2);

  // result record carried through the output stage
  typedef struct packed {
    logic            line_level;
    logic            busy;
    logic [CntW-1:0] count;
    logic            overflow;
  } res_t;

  // ---------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------
  logic [WORD_BITS-1:0] pack_q, pack_d;
  logic [PosW-1:0]      pos_q, pos_d;
  logic [AddrW-1:0]     head_q, head_d;
  logic [AddrW-1:0]     tail_q, tail_d;
  logic [CntW-1:0]      fill_q, fill_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic                 sending_q, sending_d;
  logic                 line_q, line_d;
  logic [WORD_BITS-1:0] shift_q;
  logic [WORD_BITS-1:0] mem [FIFO_DEPTH];

  logic                 in_acc;
  logic                 push_en, pop_en, shift_en, dropped;
  logic [WORD_BITS-1:0] word_w, enc_w;

  // output stage: result register plus one skid entry
  res_t res_q, skid_q, res_new;
  logic res_valid_q, skid_valid_q;
  logic out_take;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign out_take   = res_valid_q && !out_stall_i;

  // byte lands at its position above the bytes already packed, then the key
  assign word_w = pack_q | (WORD_BITS'(data_byte_i) << (BYTE_BITS * int'(pos_q)));
  assign enc_w  = word_w ^ WORD_BITS'(key_word_i);

  // ---------------------------------------------------------------------------
  // next state for one item
  // ---------------------------------------------------------------------------
  always_comb begin
    pack_d    = pack_q;
    pos_d     = pos_q;
    head_d    = head_q;
    tail_d    = tail_q;
    fill_d    = fill_q;
    idx_d     = idx_q;
    sending_d = sending_q;
    line_d    = line_q;
    push_en   = 1'b0;
    pop_en    = 1'b0;
    shift_en  = 1'b0;
    dropped   = 1'b0;
    if (in_acc) begin
      unique case (cmd_e'(command_i))
        CMD_PUSH: begin
          if (last_byte_i || pos_q == PosW'(BytesPerWord - 1)) begin
            // word complete: queue it, or drop it when the queue is full
            if (fill_q == CntW'(FIFO_DEPTH)) begin
              dropped = 1'b1;
            end else begin
              push_en = 1'b1;
              tail_d  = (tail_q == AddrW'(FIFO_DEPTH - 1)) ? '0 : tail_q + 1'b1;
              fill_d  = fill_q + 1'b1;
            end
            pack_d = '0;
            pos_d  = '0;
          end else begin
            pack_d = word_w;
            pos_d  = pos_q + 1'b1;
          end
        end
        CMD_TICK: begin
          priority if (!sending_q) begin
            // idle: start a frame if a word waits
            if (fill_q != '0) begin
              pop_en    = 1'b1;
              head_d    = (head_q == AddrW'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
              fill_d    = fill_q - 1'b1;
              line_d    = 1'b0;
              idx_d     = '0;
              sending_d = 1'b1;
            end
          end else if (idx_q < IdxW'(WORD_BITS)) begin
            // data bit, lsb first
            shift_en = 1'b1;
            line_d   = shift_q[0];
            idx_d    = idx_q + 1'b1;
          end else if (idx_q == IdxW'(WORD_BITS)) begin
            // stop bit
            line_d = 1'b1;
            idx_d  = idx_q + 1'b1;
          end else begin
            // closing tick, line stays high
            sending_d = 1'b0;
            idx_d     = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_new.line_level = line_d;
    res_new.busy       = sending_d;
    res_new.count      = fill_d;
    res_new.overflow   = dropped;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_q    <= '0;
      pos_q     <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      fill_q    <= '0;
      idx_q     <= '0;
      sending_q <= 1'b0;
      line_q    <= 1'b1;
    end else begin
      pack_q    <= pack_d;
      pos_q     <= pos_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      fill_q    <= fill_d;
      idx_q     <= idx_d;
      sending_q <= sending_d;
      line_q    <= line_d;
    end
  end

  // queue storage and shift register; the pop read lands straight in the
  // shift register, ahead of the first data tick
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      mem[tail_q] <= enc_w;
    end
    if (pop_en) begin
      shift_q <= mem[head_q];
    end else if (shift_en) begin
      shift_q <= shift_q >> 1;
    end
  end

  // ---------------------------------------------------------------------------
  // output stage
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // no input transfer while the skid entry is full
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (res_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end
      res_valid_q <= 1'b1;
    end else if (out_take) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        res_q <= skid_q;
      end
    end else if (in_acc) begin
      if (res_valid_q && !out_take) begin
        skid_q <= res_new;
      end else begin
        res_q <= res_new;
      end
    end
  end

  assign out_valid_o  = res_valid_q;
  assign line_level_o = res_q.line_level;
  assign busy_res_o   = res_q.busy;
  assign fifo_count_o = res_q.count;
  assign overflow_o   = res_q.overflow;

endmodule

`default_nettype wire

// File: design/wfos_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module wfos_checker
  import wfos_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic                       line_level_o,
  input wire logic                       busy_res_o,
  input wire logic [$clog2(FIFO_DEPTH+1)-1:0] fifo_count_o,
  input wire logic                       overflow_o
);

  localparam int CntW = $clog2(FIFO_DEPTH + 1);

  // a stalled result stays put
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(line_level_o)
      && $stable(busy_res_o) && $stable(fifo_count_o) && $stable(overflow_o))
    else $error("result changed under stall");

  // queue never reports more words than it holds
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fifo_count_o <= CntW'(FIFO_DEPTH))
    else $error("queue count beyond depth");

  // a word is only dropped on a full queue
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> fifo_count_o == CntW'(FIFO_DEPTH))
    else $error("overflow with room in queue");

  // the line idles high outside a frame
  a_idle_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> line_level_o)
    else $error("line low while idle");

endmodule

bind word_fifo_onoff_serializer wfos_checker #(
  .FIFO_DEPTH(FIFO_DEPTH)
) u_wfos_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .line_level_o(line_level_o),
  .busy_res_o  (busy_res_o),
  .fifo_count_o(fifo_count_o),
  .overflow_o  (overflow_o)
);

`default_nettype wire
